// File: sv/tdet_pkg.sv
package tdet_pkg;

  // Number of request slots and the most expiries freed on one tick.
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [19:0] US_MAX   = 20'd999999;
  localparam logic [20:0] US_PER_S = 21'd1000000;

  // Function codes carried on the input tuser.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_POST = 2'd1;
  localparam logic [1:0] FUNC_SET  = 2'd2;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_EXPIRED  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TICK_S  = 1'b0;
  localparam logic CFG_TICK_US = 1'b1;

  typedef struct packed {
    logic [7:0]  tag;
    logic        kind;
    logic [31:0] sec;
    logic [19:0] usec;
  } slot_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
  } clock_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // tick accepted: advance clocks, begin scan at slot 0
    logic post;      // post request accepted
    logic set_wall;  // set wall clock accepted
    logic check;     // evaluate the slot under the scan index
    logic step;      // move the scan index to the next slot
    logic flush;     // hand over the held expiry as the final result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic held_valid;
    logic out_free;
    logic idx_last;
  } stat_t;

  function automatic clock_t advance(clock_t c, logic [3:0] ts, logic [19:0] tus);
    logic [20:0] u;
    logic [31:0] s;
    clock_t      r;
    u = {1'b0, c.usec} + {1'b0, tus};
    s = c.sec + {28'd0, ts};
    if (u > {1'b0, US_MAX}) begin
      s = s + 32'd1;
      u = u - US_PER_S;
      if (u > {1'b0, US_MAX}) begin
        u = {1'b0, US_MAX};
      end
    end
    r.sec  = s;
    r.usec = u[19:0];
    return r;
  endfunction

  function automatic logic earlier(logic [31:0] ds, logic [19:0] du, clock_t c);
    return (ds < c.sec) || ((ds == c.sec) && (du < c.usec));
  endfunction

endpackage

// File: sv/tdet_ram.sv
module tdet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tdet_ctrl.sv
module tdet_ctrl
  import tdet_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  output logic       in_ready,
  input  stat_t      st,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  logic   accept;
  logic   stall;

  assign in_ready = (state == IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  // A second expiry cannot be taken while the held one has nowhere to go.
  assign stall = st.hit && st.held_valid && !st.out_free;

  always_comb begin
    cmd          = '0;
    cmd.start    = accept && (func == FUNC_TICK);
    cmd.post     = accept && (func == FUNC_POST);
    cmd.set_wall = accept && (func == FUNC_SET);
    cmd.check    = (state == SCAN) && !stall;
    cmd.step     = (state == SCAN) && !stall && !st.idx_last;
    cmd.flush    = (state == FLUSH) && st.held_valid && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept && (func == FUNC_TICK)) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (!stall && st.idx_last) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          if (!st.held_valid || st.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: sv/tdet_dp.sv
module tdet_dp
  import tdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [63:0] in_data,
  input  logic        cfg_wr,
  input  logic        cfg_idx,
  input  logic [19:0] cfg_val,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_tag,
  output logic        out_last
);

  logic [3:0]       tick_s;
  logic [19:0]      tick_us;
  clock_t           wall;
  clock_t           elapsed;
  logic [SLOTS-1:0] slot_valid;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic             held_valid;
  logic [7:0]       held_tag;

  slot_t            req;
  slot_t            rd;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;
  logic             due;
  logic             out_free;
  logic             hit;

  assign req.tag  = in_data[7:0];
  assign req.kind = in_data[8];
  assign req.sec  = in_data[40:9];
  assign req.usec = in_data[60:41];

  // Lowest free slot for a post.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_valid[i] && !free_found) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd.start) begin
      raddr = '0;
    end else if (cmd.step) begin
      raddr = idx + IDX_W'(1);
    end else begin
      raddr = idx;
    end
  end

  tdet_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.post && free_found),
    .waddr (free_idx),
    .wdata (req),
    .raddr (raddr),
    .rdata (rd)
  );

  assign due = rd.kind ? earlier(rd.sec, rd.usec, wall) : earlier(rd.sec, rd.usec, elapsed);
  assign hit = slot_valid[idx] && due && (count < CNT_W'(MAX_RESULTS));
  assign out_free = !out_valid || out_ready;

  assign st.hit        = hit;
  assign st.held_valid = held_valid;
  assign st.out_free   = out_free;
  assign st.idx_last   = (idx == IDX_W'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_s     <= 4'd0;
      tick_us    <= 20'd20000;
      wall       <= '0;
      elapsed    <= '0;
      slot_valid <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          CFG_TICK_S:  tick_s  <= cfg_val[3:0];
          CFG_TICK_US: tick_us <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.start) begin
        wall    <= advance(wall, tick_s, tick_us);
        elapsed <= advance(elapsed, tick_s, tick_us);
      end
      if (cmd.set_wall) begin
        wall.sec  <= req.sec;
        wall.usec <= req.usec;
      end
      if (cmd.post && free_found) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
      end
      if (cmd.check && hit) begin
        slot_valid[idx] <= 1'b0;
        held_valid      <= 1'b1;
        if (held_valid) begin
          out_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        held_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx   <= '0;
      count <= '0;
    end else if (cmd.step) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.check && hit) begin
      count    <= count + CNT_W'(1);
      held_tag <= rd.tag;
    end
    if (cmd.post) begin
      out_status <= free_found ? ST_ACCEPTED : ST_FULL;
      out_tag    <= req.tag;
      out_last   <= 1'b1;
    end else if (cmd.check && hit && held_valid) begin
      out_status <= ST_EXPIRED;
      out_tag    <= held_tag;
      out_last   <= 1'b0;
    end else if (cmd.flush) begin
      out_status <= ST_EXPIRED;
      out_tag    <= held_tag;
      out_last   <= 1'b1;
    end
  end

endmodule

// File: sv/timer_deadline_expiry_table_core.sv
// Timer deadline table. The block keeps a wall clock and an elapsed clock, each
// as 32-bit seconds plus microseconds, and a table of SLOTS pending requests.
// A tick (func 0) adds the configured period to both clocks, then walks the
// table one slot per clock cycle, pausing while an expiry is held and the
// output cannot take the next, reading the slot memory at the scan index,
// and frees and reports every request whose deadline is strictly earlier than
// its clock (delays against the elapsed clock, alarms against the wall clock)
// in ascending slot order; the final report carries tlast. A tick is
// accepted, scans every slot, then closes by flushing the held expiry.
// A post (func 1) answers with one result: accepted, or full when no slot is
// free; a set-time (func 2) loads the wall clock. A new request is taken only
// while the block is idle and the output register is free or being emptied.
// Configuration registers should be written only while the block is idle.
module timer_deadline_expiry_table_core
  import tdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request input.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: request_tag[7:0], request_kind, time_seconds[31:0],
  // time_microseconds[19:0], zero fill to 64 bits.
  input  logic [63:0] s_tdata,
  // tuser: func[1:0].
  input  logic [1:0]  s_tuser,
  // Result output.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: tag_out[7:0].
  output logic [7:0]  m_tdata,
  // tuser: status[1:0].
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  // Configuration writes: index 0 tick_seconds, index 1 tick_microseconds.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  tdet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tdet_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_data    (s_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_tag    (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
